// ----- rtl/fete_pkg.sv -----
// Shared types, register codes and fixed-point helpers for the escape-time fractal engine.
`timescale 1ns / 1ps
`default_nettype none

package fete_pkg;

    // Complex values are signed Q4.28 in 32 bits.
    localparam int Q_W    = 32;
    localparam int FRAC_W = 28;

    typedef logic signed [Q_W-1:0] q_t;

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;

    // Fractal mode codes. The unused code runs as Mandelbrot.
    localparam logic [1:0] MODE_MANDEL = 2'd0;
    localparam logic [1:0] MODE_JULIA  = 2'd1;
    localparam logic [1:0] MODE_SHIP   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_CENTER_RE  = 3'd1;
    localparam logic [2:0] REG_CENTER_IM  = 3'd2;
    localparam logic [2:0] REG_PIXEL_STEP = 3'd3;
    localparam logic [2:0] REG_SEED_RE    = 3'd4;
    localparam logic [2:0] REG_SEED_IM    = 3'd5;
    localparam logic [2:0] REG_MAX_ITER   = 3'd6;
    localparam logic [2:0] REG_BAILOUT    = 3'd7;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Depth of the job queue between the front and back parts.
    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } pixel_t;

    typedef struct packed {
        logic [15:0] iteration_count;
        logic        inside_res;
    } result_t;

    typedef struct packed {
        logic [1:0]  mode;
        q_t          center_re;
        q_t          center_im;
        logic [30:0] pixel_step;
        q_t          seed_re;
        q_t          seed_im;
        logic [15:0] max_iterations;
        logic [30:0] bailout;
    } cfg_t;

    // One mapped point, ready for the iterator.
    typedef struct packed {
        q_t   z_re;
        q_t   z_im;
        q_t   c_re;
        q_t   c_im;
        logic ship;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic res_load;
    } back_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_HOLD
    } back_state_t;

    // Saturate a 38-bit signed value to the Q4.28 range.
    function automatic q_t sat38(input logic signed [37:0] v);
        logic fits;
        fits = (&v[37:31]) || (~|v[37:31]);
        if (fits) begin
            return v[31:0];
        end
        return v[37] ? Q_MIN : Q_MAX;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fractal_escape_time_engine_core.sv -----
// Top level of the escape-time fractal engine: config port, mapper, job queue, iterator.
`timescale 1ns / 1ps
`default_nettype none

// Each request carries one pixel position; the engine maps it to the complex
// point center + (pixel - size/2) * pixel_step (saturated, signed Q4.28) and
// iterates z = z^2 + c in Mandelbrot, Julia or Burning Ship mode, returning
// the iteration count and an inside flag, one result per request and in
// order. The iterator does one complex squaring per cycle, with three 32x32
// multipliers feeding both the escape test of the current z and the next z.
// The mapper in front registers its products before the mapped point enters
// the job queue. The mapper overlaps with the iterator through a two-entry
// job queue, and a finished result waits in its own register, so the next
// pixel can be mapped and started while the previous result is still unread.
// Configuration must be written through the APB-style port only while no
// request is in flight; the engine itself does not enforce this.
module fractal_escape_time_engine_core #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            push,
    output logic                           full,
    input  wire fete_pkg::pixel_t          pixel,
    output logic                           empty,
    input  wire                            pop,
    output fete_pkg::result_t              result,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [fete_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire [fete_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fete_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import fete_pkg::*;

    cfg_t       cfg;
    job_t       front_job;
    job_t       back_job;
    logic       job_push;
    logic       job_pop;
    q_stat_t    q_stat;
    back_stat_t back_stat;

    // The register file never stalls the bus.
    assign pready = 1'b1;

    fete_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // The mapper holds one request in its product stage and stalls only when
    // that stage is full and the queue cannot take the mapped point.
    fete_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .push     (push),
        .full     (full),
        .pixel    (pixel),
        .q_stat   (q_stat),
        .job_push (job_push),
        .job      (front_job)
    );

    fete_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (job_push),
        .wr_data (front_job),
        .rd      (job_pop),
        .rd_data (back_job),
        .stat    (q_stat)
    );

    // The iterator pulls a job whenever it is idle and keeps a finished count
    // until the result register frees up.
    fete_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .job     (back_job),
        .q_stat  (q_stat),
        .job_pop (job_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .stat    (back_stat)
    );

    // The queue can never report full and empty together.
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("job queue reports full and empty at once");

    // The mapper never writes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_stat.full)
        else $error("job pushed into a full queue");

    // A job is taken only from a non-empty queue and only by an idle iterator.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> (!q_stat.empty && !back_stat.busy))
        else $error("job popped while empty or while iterating");

    // A newly loaded result is visible in the next cycle.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.res_load |=> !empty)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- rtl/fete_cfg.sv -----
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module fete_cfg (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [fete_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire [fete_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fete_pkg::CFG_DATA_W-1:0] prdata,
    output fete_pkg::cfg_t                cfg
);
    import fete_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx   = paddr[CFG_ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.mode           <= MODE_MANDEL;
            cfg_reg.center_re      <= '0;
            cfg_reg.center_im      <= '0;
            cfg_reg.pixel_step     <= 31'd1048576;
            cfg_reg.seed_re        <= '0;
            cfg_reg.seed_im        <= '0;
            cfg_reg.max_iterations <= 16'd100;
            cfg_reg.bailout        <= 31'd1073741824;
        end
        else if (wr_en) begin
            unique case (idx)
                REG_MODE:       cfg_reg.mode           <= pwdata[1:0];
                REG_CENTER_RE:  cfg_reg.center_re      <= $signed(pwdata);
                REG_CENTER_IM:  cfg_reg.center_im      <= $signed(pwdata);
                REG_PIXEL_STEP: cfg_reg.pixel_step     <= pwdata[30:0];
                REG_SEED_RE:    cfg_reg.seed_re        <= $signed(pwdata);
                REG_SEED_IM:    cfg_reg.seed_im        <= $signed(pwdata);
                REG_MAX_ITER:   cfg_reg.max_iterations <= pwdata[15:0];
                REG_BAILOUT:    cfg_reg.bailout        <= pwdata[30:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MODE:       prdata = {30'd0, cfg_reg.mode};
            REG_CENTER_RE:  prdata = cfg_reg.center_re;
            REG_CENTER_IM:  prdata = cfg_reg.center_im;
            REG_PIXEL_STEP: prdata = {1'b0, cfg_reg.pixel_step};
            REG_SEED_RE:    prdata = cfg_reg.seed_re;
            REG_SEED_IM:    prdata = cfg_reg.seed_im;
            REG_MAX_ITER:   prdata = {16'd0, cfg_reg.max_iterations};
            REG_BAILOUT:    prdata = {1'b0, cfg_reg.bailout};
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/fete_front.sv -----
// Front part: accepts pixel requests and maps them to complex starting points.
`timescale 1ns / 1ps
`default_nettype none

module fete_front #(
    parameter int IMAGE_WIDTH  = 1024,
    parameter int IMAGE_HEIGHT = 1024
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire fete_pkg::cfg_t    cfg,
    input  wire                  push,
    output logic                 full,
    input  wire fete_pkg::pixel_t  pixel,
    input  wire fete_pkg::q_stat_t q_stat,
    output logic                 job_push,
    output fete_pkg::job_t       job
);
    import fete_pkg::*;

    localparam int MAX_DIM = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int DIM_W   = ($clog2(MAX_DIM) > 10) ? $clog2(MAX_DIM) : 10;
    localparam int OFF_W   = DIM_W + 2;
    localparam int PROD_W  = OFF_W + Q_W;
    localparam int SUM_W   = PROD_W + 1;

    localparam logic signed [OFF_W-1:0] HALF_X = OFF_W'(IMAGE_WIDTH / 2);
    localparam logic signed [OFF_W-1:0] HALF_Y = OFF_W'(IMAGE_HEIGHT / 2);

    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] s1_prod_re_reg;
    logic signed [PROD_W-1:0] s1_prod_im_reg;

    logic signed [OFF_W-1:0]  off_x;
    logic signed [OFF_W-1:0]  off_y;
    logic signed [Q_W-1:0]    step_s;
    logic signed [PROD_W-1:0] prod_re;
    logic signed [PROD_W-1:0] prod_im;
    logic signed [SUM_W-1:0]  sum_re;
    logic signed [SUM_W-1:0]  sum_im;
    q_t                       p_re;
    q_t                       p_im;
    logic                     accept;
    logic                     julia;

    assign job_push = s1_valid_reg && !q_stat.full;
    assign full     = s1_valid_reg && q_stat.full;
    assign accept   = push && !full;

    assign off_x   = $signed(OFF_W'(pixel.pixel_x)) - HALF_X;
    assign off_y   = $signed(OFF_W'(pixel.pixel_y)) - HALF_Y;
    assign step_s  = $signed({1'b0, cfg.pixel_step});
    assign prod_re = PROD_W'(off_x) * PROD_W'(step_s);
    assign prod_im = PROD_W'(off_y) * PROD_W'(step_s);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept) begin
            s1_valid_reg <= 1'b1;
        end
        else if (job_push) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            s1_prod_re_reg <= prod_re;
            s1_prod_im_reg <= prod_im;
        end
    end

    // Add the view center and clamp to the Q4.28 range.
    always_comb begin
        sum_re = SUM_W'(s1_prod_re_reg) + SUM_W'(cfg.center_re);
        sum_im = SUM_W'(s1_prod_im_reg) + SUM_W'(cfg.center_im);
        if ((&sum_re[SUM_W-1:Q_W-1]) || (~|sum_re[SUM_W-1:Q_W-1])) begin
            p_re = sum_re[Q_W-1:0];
        end
        else begin
            p_re = sum_re[SUM_W-1] ? Q_MIN : Q_MAX;
        end
        if ((&sum_im[SUM_W-1:Q_W-1]) || (~|sum_im[SUM_W-1:Q_W-1])) begin
            p_im = sum_im[Q_W-1:0];
        end
        else begin
            p_im = sum_im[SUM_W-1] ? Q_MIN : Q_MAX;
        end
    end

    // Julia starts from the point and adds the seed; the other modes start at zero.
    always_comb begin
        julia    = (cfg.mode == MODE_JULIA);
        job.ship = (cfg.mode == MODE_SHIP);
        job.z_re = julia ? p_re : '0;
        job.z_im = julia ? p_im : '0;
        job.c_re = julia ? cfg.seed_re : p_re;
        job.c_im = julia ? cfg.seed_im : p_im;
    end

endmodule

`default_nettype wire

// ----- rtl/fete_queue.sv -----
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module fete_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                wr,
    input  wire fete_pkg::job_t  wr_data,
    input  wire                rd,
    output fete_pkg::job_t     rd_data,
    output fete_pkg::q_stat_t  stat
);
    import fete_pkg::*;

    job_t                 entry_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg;
    logic [JOB_PTR_W-1:0] rd_ptr_reg;
    logic [JOB_CNT_W-1:0] count_reg;
    logic [JOB_CNT_W-1:0] count_next;

    assign stat.full  = (count_reg == JOB_CNT_W'(JOB_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (wr && !rd) begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            count_reg <= count_next;
            if (wr) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fete_back.sv -----
// Back part: iterates z = z^2 + c and holds the finished result.
`timescale 1ns / 1ps
`default_nettype none

module fete_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire fete_pkg::cfg_t     cfg,
    input  wire fete_pkg::job_t     job,
    input  wire fete_pkg::q_stat_t  q_stat,
    output logic                  job_pop,
    output logic                  empty,
    input  wire                   pop,
    output fete_pkg::result_t     result,
    output fete_pkg::back_stat_t  stat
);
    import fete_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    q_t          zx_reg;
    q_t          zy_reg;
    q_t          c_re_reg;
    q_t          c_im_reg;
    logic        ship_reg;
    logic        first_reg;
    logic [15:0] cnt_reg;
    logic        res_valid_reg;
    result_t     res_reg;

    logic signed [63:0] sq_re;
    logic signed [63:0] sq_im;
    logic signed [63:0] prod_xy;
    logic signed [63:0] diff;
    logic signed [35:0] re_f;
    logic signed [36:0] im_f;
    logic signed [36:0] im_sel;
    q_t                 re_sat;
    q_t                 zx_next;
    q_t                 zy_next;
    logic [63:0]        mag;
    logic [63:0]        limit;
    logic               escape;
    logic [16:0]        cnt_inc;
    logic               iter_done;
    logic [15:0]        fin_cnt;
    logic               slot_free;
    logic               res_load;
    logic               z_step;
    logic [15:0]        res_cnt;

    // One iteration per cycle: the squares of the current z give both its escape
    // test and the next z.
    always_comb begin
        sq_re   = 64'(zx_reg) * 64'(zx_reg);
        sq_im   = 64'(zy_reg) * 64'(zy_reg);
        prod_xy = 64'(zx_reg) * 64'(zy_reg);
        diff    = sq_re - sq_im;
        re_f    = diff[63:FRAC_W];
        im_f    = prod_xy[63:FRAC_W-1];
        im_sel  = (ship_reg && im_f[36]) ? -im_f : im_f;
        zy_next = sat38(38'(im_sel) + 38'(c_im_reg));
        re_sat  = sat38(38'(re_f) + 38'(c_re_reg));
        if (ship_reg && re_sat[Q_W-1]) begin
            zx_next = (re_sat == Q_MIN) ? Q_MAX : -re_sat;
        end
        else begin
            zx_next = re_sat;
        end
        mag    = $unsigned(sq_re) + $unsigned(sq_im);
        limit  = {5'd0, cfg.bailout, 28'd0};
        escape = !first_reg && (mag >= limit);
    end

    // Loop control: the starting point is never tested, later points are.
    always_comb begin
        cnt_inc   = {1'b0, cnt_reg} + 17'd1;
        iter_done = 1'b0;
        fin_cnt   = cnt_reg;
        if (first_reg) begin
            iter_done = (cnt_reg >= cfg.max_iterations);
        end
        else if (escape) begin
            iter_done = 1'b1;
        end
        else if (cnt_inc >= {1'b0, cfg.max_iterations}) begin
            iter_done = 1'b1;
            fin_cnt   = cnt_inc[15:0];
        end
    end

    assign slot_free = !res_valid_reg || pop;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = ST_ITER;
                end
            end
            ST_ITER: begin
                if (iter_done) begin
                    state_next = slot_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        job_pop  = 1'b0;
        res_load = 1'b0;
        z_step   = 1'b0;
        res_cnt  = fin_cnt;
        unique case (state_reg)
            ST_IDLE: begin
                job_pop = !q_stat.empty;
            end
            ST_ITER: begin
                res_load = iter_done && slot_free;
                z_step   = !iter_done;
            end
            ST_HOLD: begin
                res_load = slot_free;
                res_cnt  = cnt_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            if (res_load) begin
                res_valid_reg <= 1'b1;
            end
            else if (pop) begin
                res_valid_reg <= 1'b0;
            end
            if (job_pop) begin
                first_reg <= 1'b1;
            end
            else if (z_step) begin
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (job_pop) begin
            zx_reg   <= job.z_re;
            zy_reg   <= job.z_im;
            c_re_reg <= job.c_re;
            c_im_reg <= job.c_im;
            ship_reg <= job.ship;
            cnt_reg  <= 16'd1;
        end
        else if (z_step) begin
            zx_reg <= zx_next;
            zy_reg <= zy_next;
            if (!first_reg) begin
                cnt_reg <= cnt_inc[15:0];
            end
        end
        else if (state_reg == ST_ITER) begin
            cnt_reg <= fin_cnt;
        end
        if (res_load) begin
            res_reg.iteration_count <= res_cnt;
            res_reg.inside_res      <= (res_cnt == cfg.max_iterations);
        end
    end

    assign empty         = !res_valid_reg;
    assign result        = res_reg;
    assign stat.busy     = (state_reg != ST_IDLE);
    assign stat.res_load = res_load;

endmodule

`default_nettype wire

// ----- tb/fractal_escape_time_engine_core_tb.sv -----
// Self-checking testbench for the escape-time fractal engine core.
`timescale 1ns / 1ps

// The bench pushes pixel requests into the engine and pops one result per
// request. A behavioral predictor works out the iteration count and inside
// flag of every accepted request from its own copy of the configuration
// registers. Each popped result is compared with the oldest prediction.
//
// The configuration registers are written over the APB-style port, but only
// while no request is in flight. Named test tasks run in turn:
//   - directed requests at the reset view,
//   - each fractal mode, including the unused mode code,
//   - the iteration limit below two, a zero bailout and saturating views,
//   - one request at the largest limit that never escapes,
//   - random views with random pixels,
//   - a long receiver hold-off that fills the engine,
//   - a sender pause until every result has come back.
// Both sides insert random gaps. A watchdog ends the run when nothing is
// accepted for too long.
module fractal_escape_time_engine_core_tb;

    import fete_pkg::*;

    localparam int IMG_W = 1024;
    localparam int IMG_H = 1024;

    // Mapping offsets: half the image size, by integer division.
    localparam longint HALF_W = IMG_W / 2;
    localparam longint HALF_H = IMG_H / 2;

    // Q4.28 range as 64-bit values for the predictor's wide arithmetic.
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    // The mode code that has no fractal of its own.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Common Q4.28 values.
    localparam logic [31:0] STEP_DEF  = 32'd1048576;
    localparam logic [31:0] BAIL_DEF  = 32'h4000_0000;
    localparam logic [31:0] U31_MAX   = 32'h7FFF_FFFF;

    // No acceptance for this many cycles means the engine hangs. The slowest
    // correct request is a point that never escapes at the largest limit,
    // plus a long receiver stall.
    localparam int WATCHDOG_LIMIT = 400000;

    // Cycles to keep watching the result side after the last result.
    localparam int TAIL_CYCLES = 400;

    localparam int MAX_REPORTS = 10;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    pixel_t      pixel;
    logic        empty;
    logic        pop;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic        pready;

    fractal_escape_time_engine_core #(
        .IMAGE_WIDTH  (IMG_W),
        .IMAGE_HEIGHT (IMG_H)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .pixel   (pixel),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The predictor's copy of the configuration registers.
    cfg_t cfg_mirror;

    // Predicted results of accepted requests, oldest first.
    result_t escape_q[$];

    int mismatches;
    int idle_cycles;

    // Requests from the test tasks to the handshake processes.
    bit quiet_both;      // no gaps on either side
    bit sender_rush;     // no gaps on the sender side
    int pop_hold_req;    // receiver hold-off length, taken by the receiver

    result_t want;

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_q(input longint v);
        if (v > SAT_HI) begin
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            return SAT_LO;
        end
        return v;
    endfunction

    // Iteration count and inside flag of one pixel under the mirrored view.
    function automatic result_t predict_escape(input pixel_t p);
        longint pre;
        longint pim;
        longint zx;
        longint zy;
        longint cre;
        longint cim;
        longint re;
        longint im;
        longint step;
        longint unsigned sq_x;
        longint unsigned sq_y;
        longint unsigned escape_lim;
        int unsigned iter;
        bit ship;
        result_t r;

        step = longint'(cfg_mirror.pixel_step);
        pre  = clamp_q(longint'($signed(cfg_mirror.center_re))
                       + (longint'(p.pixel_x) - HALF_W) * step);
        pim  = clamp_q(longint'($signed(cfg_mirror.center_im))
                       + (longint'(p.pixel_y) - HALF_H) * step);

        // The unused mode code falls through to Mandelbrot.
        ship = (cfg_mirror.mode == MODE_SHIP);
        if (cfg_mirror.mode == MODE_JULIA) begin
            zx  = pre;
            zy  = pim;
            cre = longint'($signed(cfg_mirror.seed_re));
            cim = longint'($signed(cfg_mirror.seed_im));
        end else begin
            zx  = 0;
            zy  = 0;
            cre = pre;
            cim = pim;
        end

        escape_lim = 64'(cfg_mirror.bailout);
        escape_lim = escape_lim << FRAC_W;

        iter = 1;
        while (iter < 32'(cfg_mirror.max_iterations)) begin
            // Arithmetic shifts of the signed products floor toward minus infinity.
            re = (zx * zx - zy * zy) >>> FRAC_W;
            im = (zx * zy) >>> (FRAC_W - 1);
            if (ship) begin
                zy = clamp_q(((im < 0) ? -im : im) + cim);
                zx = clamp_q(re + cre);
                zx = clamp_q((zx < 0) ? -zx : zx);
            end else begin
                zy = clamp_q(im + cim);
                zx = clamp_q(re + cre);
            end
            // The exact squared magnitude can reach 2^63, so it is summed unsigned.
            sq_x = zx * zx;
            sq_y = zy * zy;
            if (sq_x + sq_y >= escape_lim) begin
                break;
            end
            iter++;
        end

        r.iteration_count = iter[15:0];
        r.inside_res      = (iter == 32'(cfg_mirror.max_iterations));
        return r;
    endfunction

    function automatic void mirror_reset();
        cfg_mirror                = '0;
        cfg_mirror.mode           = MODE_MANDEL;
        cfg_mirror.pixel_step     = STEP_DEF[30:0];
        cfg_mirror.max_iterations = 16'd100;
        cfg_mirror.bailout        = BAIL_DEF[30:0];
    endfunction

    // ------------------------------------------------------------------
    // Idle gaps: mostly none or short, now and then a long one.
    // ------------------------------------------------------------------

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 120);
    endfunction

    // ------------------------------------------------------------------
    // Checking and prediction, all sampled at the rising edge.
    // ------------------------------------------------------------------

    // The result side is checked before a request accepted at the same edge
    // is predicted, so a result can never be matched with its own request.
    always @(posedge clk) begin
        if (rst_n) begin
            if (pop && !empty) begin
                if (escape_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] unexpected result: count %0d inside %0d",
                                 $realtime, result.iteration_count, result.inside_res);
                    end
                end else begin
                    want = escape_q.pop_front();
                    if (result.iteration_count !== want.iteration_count
                        || result.inside_res !== want.inside_res) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("[%0t] count exp %0d got %0d, inside exp %0d got %0d",
                                     $realtime, want.iteration_count,
                                     result.iteration_count, want.inside_res,
                                     result.inside_res);
                        end
                    end
                end
            end
            if (push && !full) begin
                escape_q.push_back(predict_escape(pixel));
            end
        end
    end

    // Watchdog: any accepted request, result or register write restarts it.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty) || (psel && penable && pready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("fractal_escape_time_engine_core test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: pops with random gaps, and holds off on request.
    // ------------------------------------------------------------------

    initial begin : receiver
        bit took;
        int gap_left;
        int hold_cnt;
        pop      = 1'b0;
        gap_left = 0;
        hold_cnt = 0;
        forever begin
            @(posedge clk);
            took = pop && !empty;
            @(negedge clk);
            if (pop_hold_req > 0) begin
                hold_cnt     = pop_hold_req;
                pop_hold_req = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                pop <= 1'b0;
            end else begin
                if (took) begin
                    gap_left = pick_gap(quiet_both);
                end else if (gap_left > 0) begin
                    gap_left--;
                end
                pop <= (gap_left == 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender and register port
    // ------------------------------------------------------------------

    // Offers one pixel request after a random gap and returns once it is
    // accepted. push stays high when the next request follows without a gap.
    task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
        int n;
        pixel_t pk;
        n = pick_gap(quiet_both || sender_rush);
        if (n > 0) begin
            @(negedge clk);
            push <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        pk.pixel_x = x;
        pk.pixel_y = y;
        @(negedge clk);
        pixel <= pk;
        push  <= 1'b1;
        do @(posedge clk); while (full);
    endtask

    task automatic send_random_pixel();
        if ($urandom_range(0, 9) == 0) begin
            // Image corners and edges stress the mapping extremes.
            send_pixel($urandom_range(0, 1) ? 10'd1023 : 10'd0,
                       $urandom_range(0, 1) ? 10'd1023 : 10'd0);
        end else begin
            send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
        end
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (escape_q.size() != 0) @(negedge clk);
    endtask

    // Two-phase register write; call only while the engine is drained.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_MODE:       cfg_mirror.mode           = value[1:0];
            REG_CENTER_RE:  cfg_mirror.center_re      = value;
            REG_CENTER_IM:  cfg_mirror.center_im      = value;
            REG_PIXEL_STEP: cfg_mirror.pixel_step     = value[30:0];
            REG_SEED_RE:    cfg_mirror.seed_re        = value;
            REG_SEED_IM:    cfg_mirror.seed_im        = value;
            REG_MAX_ITER:   cfg_mirror.max_iterations = value[15:0];
            REG_BAILOUT:    cfg_mirror.bailout        = value[30:0];
            default:        ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_view(input logic [1:0] mode, input logic [31:0] cre,
                            input logic [31:0] cim, input logic [31:0] step,
                            input logic [31:0] iter_cap, input logic [31:0] bail);
        cfg_write(REG_MODE, {30'd0, mode});
        cfg_write(REG_CENTER_RE, cre);
        cfg_write(REG_CENTER_IM, cim);
        cfg_write(REG_PIXEL_STEP, step & U31_MAX);
        cfg_write(REG_MAX_ITER, iter_cap & 32'h0000_FFFF);
        cfg_write(REG_BAILOUT, bail & U31_MAX);
    endtask

    // A signed Q4.28 value: mostly in [-2, 2], sometimes any value or an extreme.
    function automatic logic [31:0] random_q();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        end
        if (r < 88) begin
            return $urandom();
        end
        return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset view: the square [-2, 2) x [-2, 2) at 100 iterations.
    task automatic test_reset_view();
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd384, 10'd512);
        send_pixel(10'd700, 10'd300);
        drain();
    endtask

    // Julia, Burning Ship and the unused mode code, which runs as Mandelbrot.
    task automatic test_fractal_modes();
        cfg_write(REG_SEED_RE, -32'sd214748365);
        cfg_write(REG_SEED_IM, 32'sd41875931);
        cfg_write(REG_MODE, {30'd0, MODE_JULIA});
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd600, 10'd450);
        send_pixel(10'd0, 10'd0);
        drain();
        cfg_write(REG_MODE, {30'd0, MODE_SHIP});
        send_pixel(10'd400, 10'd480);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd1023, 10'd0);
        drain();
        cfg_write(REG_MODE, {30'd0, MODE_UNUSED});
        send_pixel(10'd300, 10'd600);
        send_pixel(10'd512, 10'd512);
        drain();
    endtask

    // A limit of one or zero ends the loop at once; a zero bailout always escapes.
    task automatic test_limit_cases();
        set_view(MODE_MANDEL, 32'd0, 32'd0, STEP_DEF, 32'd1, BAIL_DEF);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);
        drain();
        cfg_write(REG_MAX_ITER, 32'd0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd1023, 10'd1023);
        drain();
        cfg_write(REG_MAX_ITER, 32'd100);
        cfg_write(REG_BAILOUT, 32'd0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd100, 10'd900);
        drain();
    endtask

    // Views whose mapping and iteration leave the Q4.28 range.
    task automatic test_saturation();
        set_view(MODE_MANDEL, Q_MAX, Q_MIN, U31_MAX, 32'd40, U31_MAX);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        drain();
        cfg_write(REG_SEED_RE, Q_MIN);
        cfg_write(REG_SEED_IM, Q_MAX);
        cfg_write(REG_MODE, {30'd0, MODE_JULIA});
        send_pixel(10'd512, 10'd512);
        drain();
    endtask

    // Largest limit: the origin never escapes, a corner escapes at once.
    task automatic test_deep_limit();
        set_view(MODE_MANDEL, 32'd0, 32'd0, STEP_DEF, 32'h0000_FFFF, BAIL_DEF);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);
        drain();
    endtask

    // Random views, each followed by a batch of random pixels.
    task automatic test_random_views();
        int ph;
        int k;
        int r;
        int batch;
        logic [31:0] step;
        logic [31:0] iter_cap;
        logic [31:0] bail;
        for (ph = 0; ph < 20; ph++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                step = $urandom_range(32'h0000_1000, 32'h0040_0000);
            end else if (r < 88) begin
                step = $urandom() & U31_MAX;
            end else begin
                step = $urandom_range(0, 1) ? U31_MAX : 32'd0;
            end

            r = $urandom_range(0, 99);
            if (r < 50) begin
                bail = BAIL_DEF;
            end else if (r < 85) begin
                bail = $urandom_range(1, U31_MAX);
            end else begin
                bail = $urandom_range(0, 1) ? U31_MAX : 32'd0;
            end

            // Most phases run short limits; every seventh goes deep with few pixels.
            batch = 50;
            r = $urandom_range(0, 99);
            if (ph % 7 == 6) begin
                iter_cap = $urandom_range(1000, 8000);
                batch    = 4;
            end else if (r < 80) begin
                iter_cap = $urandom_range(2, 48);
            end else if (r < 90) begin
                iter_cap = $urandom_range(0, 1);
            end else begin
                iter_cap = $urandom_range(49, 300);
            end

            set_view(2'($urandom_range(0, 3)), random_q(), random_q(), step, iter_cap, bail);
            cfg_write(REG_SEED_RE, random_q());
            cfg_write(REG_SEED_IM, random_q());

            // One phase runs back to back on both sides.
            quiet_both = (ph == 5);
            for (k = 0; k < batch; k++) begin
                send_random_pixel();
            end
            drain();
            quiet_both = 1'b0;
        end
    endtask

    // The receiver holds off while the sender keeps pushing, so the engine
    // fills up and raises full.
    task automatic test_backpressure();
        int k;
        set_view(MODE_MANDEL, 32'd0, 32'd0, STEP_DEF, 32'd24, BAIL_DEF);
        sender_rush  = 1'b1;
        pop_hold_req = 400;
        for (k = 0; k < 16; k++) begin
            send_random_pixel();
        end
        sender_rush = 1'b0;
        drain();
    endtask

    // The sender stops until every result is back, then resumes.
    task automatic test_sender_pause();
        int k;
        set_view(MODE_SHIP, -32'sd134217728, -32'sd134217728, 32'd2097152, 32'd32, BAIL_DEF);
        for (k = 0; k < 10; k++) begin
            send_random_pixel();
        end
        drain();
        for (k = 0; k < 10; k++) begin
            send_random_pixel();
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        push         = 1'b0;
        pixel        = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatches   = 0;
        idle_cycles  = 0;
        quiet_both   = 1'b0;
        sender_rush  = 1'b0;
        pop_hold_req = 0;
        mirror_reset();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_view();
        test_fractal_modes();
        test_limit_cases();
        test_saturation();
        test_deep_limit();
        test_random_views();
        test_backpressure();
        test_sender_pause();

        // Keep watching the result side for stray results.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && escape_q.size() == 0) begin
            $display("fractal_escape_time_engine_core test passed");
        end else begin
            $display("fractal_escape_time_engine_core test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/fete_pkg.sv
rtl/fete_cfg.sv
rtl/fete_front.sv
rtl/fete_queue.sv
rtl/fete_back.sv
rtl/fractal_escape_time_engine_core.sv
tb/fractal_escape_time_engine_core_tb.sv
